FILE: src/bfr_pkg.sv
// Shared types, constants and offset arithmetic for the byte ring FIFO.
`timescale 1ns / 1ps
package bfr_pkg;

	localparam int STORE_BYTES       = 4096;
	localparam int MAX_ELEMENT_BYTES = 8;
	localparam int MAX_PULL          = 64;

	localparam int DATA_W     = 64;
	localparam int LANES      = DATA_W / 8;
	localparam int LANE_W     = $clog2(LANES);
	localparam int OFF_W      = $clog2(STORE_BYTES);
	localparam int ROWS       = STORE_BYTES / LANES;
	localparam int ROW_W      = $clog2(ROWS);
	localparam int ELEM_W     = 4;
	localparam int LIM_W      = 13;
	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int COUNT_W    = 7;
	localparam int CNT_W      = $clog2(MAX_PULL + 1);
	localparam int OCC_W      = 12;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
	localparam int RESQ_DEPTH = 4;
	localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
	localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

	typedef enum logic [1:0] {
		FUNC_PUSH       = 2'd0,
		FUNC_PULL_ONE   = 2'd1,
		FUNC_PULL_COUNT = 2'd2,
		FUNC_CLEAR      = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_EMPTY   = 2'd2,
		STAT_NOTHING = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ELEMENT_BYTES = 1'd0,
		REG_BUFFER_BYTES  = 1'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_PUSH,
		CMD_PULL,
		CMD_CLEAR,
		CMD_NOTHING
	} cmd_kind_t;

	typedef enum logic {
		SQ_IDLE,
		SQ_EMIT
	} seq_state_t;

	typedef struct packed {
		func_t                func;
		logic [DATA_W-1:0]    data_in;
		logic [COUNT_W-1:0]   count;
	} item_t;

	typedef struct packed {
		status_t              status;
		logic [DATA_W-1:0]    data_out;
		logic                 last;
		logic [OCC_W-1:0]     occupancy;
		logic                 is_full;
		logic                 is_empty;
	} result_t;

	typedef struct packed {
		cmd_kind_t            kind;
		logic [DATA_W-1:0]    data;
		logic [CNT_W-1:0]     cnt;
	} cmd_t;

	// Offset of the next element slot; wraps to zero past the last whole element.
	function automatic logic [OFF_W-1:0] next_off(
		input logic [OFF_W-1:0]  off,
		input logic [ELEM_W-1:0] e,
		input logic [LIM_W-1:0]  lim
	);
		logic [LIM_W+1:0] sum;
		logic [LIM_W+1:0] ahead;
		sum   = (LIM_W+2)'(off) + (LIM_W+2)'(e);
		ahead = sum + (LIM_W+2)'(e);
		if (ahead > (LIM_W+2)'(lim)) begin
			return '0;
		end
		return sum[OFF_W-1:0];
	endfunction

endpackage

FILE: src/bfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/bfr_front.sv
// Front end: accepts items, classifies them into commands and queues them.
`timescale 1ns / 1ps
module bfr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  bfr_pkg::item_t       item,
	output logic                 cmd_valid,
	input  logic                 cmd_pop,
	output bfr_pkg::cmd_t        cmd
);

	bfr_pkg::cmd_t                     q_q [bfr_pkg::CMDQ_DEPTH];
	logic [bfr_pkg::CMDQ_PTR_W-1:0]    wr_ptr_q;
	logic [bfr_pkg::CMDQ_PTR_W-1:0]    rd_ptr_q;
	logic [bfr_pkg::CMDQ_CNT_W-1:0]    cnt_q;
	bfr_pkg::cmd_t                     cls;
	logic                              do_wr;
	logic                              do_rd;

	always_comb begin
		cls.data = item.data_in;
		cls.cnt  = bfr_pkg::CNT_W'(1);
		cls.kind = bfr_pkg::CMD_NOTHING;
		case (item.func)
			bfr_pkg::FUNC_PUSH: begin
				cls.kind = bfr_pkg::CMD_PUSH;
			end
			bfr_pkg::FUNC_PULL_ONE: begin
				cls.kind = bfr_pkg::CMD_PULL;
			end
			bfr_pkg::FUNC_PULL_COUNT: begin
				if (item.count == '0) begin
					cls.kind = bfr_pkg::CMD_NOTHING;
				end else if (item.count > bfr_pkg::COUNT_W'(bfr_pkg::MAX_PULL)) begin
					cls.kind = bfr_pkg::CMD_PULL;
					cls.cnt  = bfr_pkg::CNT_W'(bfr_pkg::MAX_PULL);
				end else begin
					cls.kind = bfr_pkg::CMD_PULL;
					cls.cnt  = bfr_pkg::CNT_W'(item.count);
				end
			end
			bfr_pkg::FUNC_CLEAR: begin
				cls.kind = bfr_pkg::CMD_CLEAR;
			end
			default: begin
				cls.kind = bfr_pkg::CMD_NOTHING;
			end
		endcase
	end

	assign full      = (cnt_q == bfr_pkg::CMDQ_CNT_W'(bfr_pkg::CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_q[rd_ptr_q];
	assign do_wr     = push && !full;
	assign do_rd     = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			q_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_cmdq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= bfr_pkg::CMDQ_CNT_W'(bfr_pkg::CMDQ_DEPTH))
	) else $error("command queue count out of range");
`endif

endmodule

FILE: src/bfr_back.sv
// Back end: ring offsets, byte-lane store and the command sequencer.
`timescale 1ns / 1ps
module bfr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [bfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfr_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          cmd_valid,
	output logic                          cmd_pop,
	input  bfr_pkg::cmd_t                 cmd,
	input  logic                          rq_full,
	output logic                          rq_push,
	output bfr_pkg::result_t              rq_data
);

	bfr_pkg::seq_state_t             state_q;
	bfr_pkg::seq_state_t             state_d;
	logic [bfr_pkg::OFF_W-1:0]       head_q;
	logic [bfr_pkg::OFF_W-1:0]       tail_q;
	logic [bfr_pkg::OFF_W-1:0]       occ_q;
	logic [bfr_pkg::ELEM_W-1:0]      elem_q;
	logic [bfr_pkg::LIM_W-1:0]       lim_q;
	bfr_pkg::status_t                st_q;
	bfr_pkg::status_t                st_d;
	logic                            pull_q;
	logic [bfr_pkg::CNT_W-1:0]       rem_q;
	logic [bfr_pkg::LANE_W-1:0]      rot_q;

	logic                            full_now;
	logic                            empty_now;
	logic                            last_now;
	logic                            wr_go;
	logic                            rd_go;
	logic                            clr_go;
	logic [7:0]                      lane_rd [bfr_pkg::LANES];
	logic [bfr_pkg::DATA_W-1:0]      pulled;

	assign full_now  = (bfr_pkg::next_off(tail_q, elem_q, lim_q) == head_q);
	assign empty_now = (head_q == tail_q);
	assign last_now  = !pull_q || (rem_q == '0) || (occ_q == '0);

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		rq_push = 1'b0;
		wr_go   = 1'b0;
		rd_go   = 1'b0;
		clr_go  = 1'b0;
		st_d    = bfr_pkg::STAT_OK;
		case (state_q)
			bfr_pkg::SQ_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = bfr_pkg::SQ_EMIT;
					case (cmd.kind)
						bfr_pkg::CMD_PUSH: begin
							if (full_now) begin
								st_d = bfr_pkg::STAT_FULL;
							end else begin
								wr_go = 1'b1;
							end
						end
						bfr_pkg::CMD_PULL: begin
							if (empty_now) begin
								st_d = bfr_pkg::STAT_EMPTY;
							end else begin
								rd_go = 1'b1;
							end
						end
						bfr_pkg::CMD_CLEAR: begin
							clr_go = 1'b1;
						end
						default: begin
							st_d = bfr_pkg::STAT_NOTHING;
						end
					endcase
				end
			end
			bfr_pkg::SQ_EMIT: begin
				if (!rq_full) begin
					rq_push = 1'b1;
					if (last_now) begin
						state_d = bfr_pkg::SQ_IDLE;
					end else begin
						rd_go = 1'b1;
					end
				end
			end
			default: begin
				state_d = bfr_pkg::SQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfr_pkg::SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
			elem_q <= bfr_pkg::ELEM_W'(1);
			lim_q  <= bfr_pkg::LIM_W'(bfr_pkg::STORE_BYTES);
			st_q   <= bfr_pkg::STAT_OK;
			pull_q <= 1'b0;
			rem_q  <= '0;
			rot_q  <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				bfr_pkg::REG_ELEMENT_BYTES: begin
					if (cfg_data[bfr_pkg::ELEM_W-1:0] == '0) begin
						elem_q <= bfr_pkg::ELEM_W'(1);
					end else if (cfg_data[bfr_pkg::ELEM_W-1:0] >
							bfr_pkg::ELEM_W'(bfr_pkg::MAX_ELEMENT_BYTES)) begin
						elem_q <= bfr_pkg::ELEM_W'(bfr_pkg::MAX_ELEMENT_BYTES);
					end else begin
						elem_q <= cfg_data[bfr_pkg::ELEM_W-1:0];
					end
					head_q <= '0;
					tail_q <= '0;
					occ_q  <= '0;
				end
				bfr_pkg::REG_BUFFER_BYTES: begin
					if (cfg_data[bfr_pkg::LIM_W-1:0] == '0) begin
						lim_q <= bfr_pkg::LIM_W'(1);
					end else if (cfg_data[bfr_pkg::LIM_W-1:0] >
							bfr_pkg::LIM_W'(bfr_pkg::STORE_BYTES)) begin
						lim_q <= bfr_pkg::LIM_W'(bfr_pkg::STORE_BYTES);
					end else begin
						lim_q <= cfg_data[bfr_pkg::LIM_W-1:0];
					end
					head_q <= '0;
					tail_q <= '0;
					occ_q  <= '0;
				end
				default: begin
				end
			endcase
		end else begin
			if (clr_go) begin
				head_q <= '0;
				tail_q <= '0;
				occ_q  <= '0;
			end
			if (wr_go) begin
				tail_q <= bfr_pkg::next_off(tail_q, elem_q, lim_q);
				occ_q  <= occ_q + 1'b1;
			end
			if (rd_go) begin
				head_q <= bfr_pkg::next_off(head_q, elem_q, lim_q);
				occ_q  <= occ_q - 1'b1;
				rot_q  <= head_q[bfr_pkg::LANE_W-1:0];
			end
			if (cmd_pop) begin
				st_q   <= st_d;
				pull_q <= rd_go;
				rem_q  <= cmd.cnt - 1'b1;
			end else if (rd_go) begin
				rem_q  <= rem_q - 1'b1;
			end
		end
	end

	for (genvar gl = 0; gl < bfr_pkg::LANES; gl++) begin : g_lane
		logic [bfr_pkg::LANE_W-1:0] wl;
		logic [bfr_pkg::LANE_W-1:0] rl;
		logic [bfr_pkg::OFF_W-1:0]  waddr_b;
		logic [bfr_pkg::OFF_W-1:0]  raddr_b;
		logic                       we;

		assign wl      = bfr_pkg::LANE_W'(gl) - tail_q[bfr_pkg::LANE_W-1:0];
		assign rl      = bfr_pkg::LANE_W'(gl) - head_q[bfr_pkg::LANE_W-1:0];
		assign waddr_b = tail_q + bfr_pkg::OFF_W'(wl);
		assign raddr_b = head_q + bfr_pkg::OFF_W'(rl);
		assign we      = wr_go && (bfr_pkg::ELEM_W'(wl) < elem_q);

		bfr_ram #(
			.WIDTH(8),
			.DEPTH(bfr_pkg::ROWS)
		) u_lane (
			.clk  (clk),
			.we   (we),
			.waddr(waddr_b[bfr_pkg::OFF_W-1:bfr_pkg::LANE_W]),
			.wdata(cmd.data[{wl, 3'b000} +: 8]),
			.re   (rd_go),
			.raddr(raddr_b[bfr_pkg::OFF_W-1:bfr_pkg::LANE_W]),
			.rdata(lane_rd[gl])
		);
	end

	always_comb begin
		logic [bfr_pkg::LANE_W-1:0] sel;
		pulled = '0;
		for (int i = 0; i < bfr_pkg::LANES; i++) begin
			sel = rot_q + bfr_pkg::LANE_W'(i);
			if (bfr_pkg::ELEM_W'(i) < elem_q) begin
				pulled[8*i +: 8] = lane_rd[sel];
			end
		end
	end

	always_comb begin
		rq_data.status    = st_q;
		rq_data.data_out  = pull_q ? pulled : '0;
		rq_data.last      = last_now;
		rq_data.occupancy = bfr_pkg::OCC_W'(occ_q);
		rq_data.is_full   = full_now;
		rq_data.is_empty  = empty_now;
	end

`ifndef SYNTHESIS
	a_occ_empty: assert property (@(posedge clk) disable iff (!arst_n)
		((occ_q == '0) == (head_q == tail_q))
	) else $error("element count disagrees with ring offsets");

	a_off_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		((bfr_pkg::LIM_W'(head_q) < lim_q) && (bfr_pkg::LIM_W'(tail_q) < lim_q))
	) else $error("ring offset beyond ring length");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q < bfr_pkg::CNT_W'(bfr_pkg::MAX_PULL))
	) else $error("remaining pull count out of range");
`endif

endmodule

FILE: src/bfr_res_q.sv
// Result queue between the sequencer and the result port.
`timescale 1ns / 1ps
module bfr_res_q (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	output logic                 wr_full,
	input  bfr_pkg::result_t     wdata,
	output logic                 empty,
	input  logic                 pop,
	output bfr_pkg::result_t     rdata
);

	bfr_pkg::result_t                  q_q [bfr_pkg::RESQ_DEPTH];
	logic [bfr_pkg::RESQ_PTR_W-1:0]    wr_ptr_q;
	logic [bfr_pkg::RESQ_PTR_W-1:0]    rd_ptr_q;
	logic [bfr_pkg::RESQ_CNT_W-1:0]    cnt_q;
	logic                              do_wr;
	logic                              do_rd;

	assign wr_full = (cnt_q == bfr_pkg::RESQ_CNT_W'(bfr_pkg::RESQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rdata   = q_q[rd_ptr_q];
	assign do_wr   = wr && !wr_full;
	assign do_rd   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			q_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/byte_ring_fifo.sv
// Top level of the byte ring FIFO: front end, sequencer and result queue.
//
// Usage: items enter on push/full/item; an item transfers at a clock edge
// with push high and full low. Results leave on empty/pop/result; the oldest
// result is on result while empty is low and transfers when pop is high.
// Configuration writes (cfg_wen, cfg_index, cfg_data) take effect at once,
// clear both ring offsets, and must be made by the user while no item is in
// flight; the block does not enforce this. An item passes the command queue,
// the sequencer's SQ_EMIT state and the result queue before its result shows.
// The sequencer ends each request before it takes the next, with one result
// per push, clear or refused request and one per element read on a pull.
// The store is eight byte-wide RAM lanes, so one element of up to eight
// bytes is written or read across the lanes in a single access.
// Reset: empty ring, element length 1 byte, ring length 4096 bytes; no
// clearing pass is needed. When the receiver stalls, the 4-entry result
// queue fills, the sequencer holds, the 2-entry command queue fills and
// full rises; no result is dropped.
`timescale 1ns / 1ps
module byte_ring_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  bfr_pkg::item_t                item,
	output logic                          empty,
	input  logic                          pop,
	output bfr_pkg::result_t              result,
	input  logic                          cfg_wen,
	input  logic [bfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfr_pkg::CFG_W-1:0]     cfg_data
);

	logic              cmd_valid;
	logic              cmd_pop;
	bfr_pkg::cmd_t     cmd;
	logic              rq_full;
	logic              rq_push;
	bfr_pkg::result_t  rq_data;

	bfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd)
	);

	bfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.rq_full  (rq_full),
		.rq_push  (rq_push),
		.rq_data  (rq_data)
	);

	bfr_res_q u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rq_push),
		.wr_full(rq_full),
		.wdata  (rq_data),
		.empty  (empty),
		.pop    (pop),
		.rdata  (result)
	);

endmodule
